### rtl/core/ata_request_sequencer_assert.svh
// ----------------------------------------------------------------------------
// ata_request_sequencer_assert.svh - assertion macros for the ATA sequencer
// Each macro samples on the rising edge of clock and is idle while reset is
// high. The including module must have signals named clock and reset.
// ----------------------------------------------------------------------------
`ifndef ATA_REQUEST_SEQUENCER_ASSERT_SVH
`define ATA_REQUEST_SEQUENCER_ASSERT_SVH

// Same-cycle implication
`define ATA_RS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ata_rs: same-cycle check failed");

// Next-cycle implication
`define ATA_RS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ata_rs: next-cycle check failed");

`endif

### rtl/core/ata_rs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_rs_pkg - shared types and constants of the ATA request sequencer
// Transaction payloads, queue entry layout, result kinds and helpers.
// ----------------------------------------------------------------------------
package ata_rs_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int LBA_W   = 28;
   localparam int COUNT_W = 8;

   // Results held per input transaction
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = 2;

   // Input command codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_IRQ     = 1'b1;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_TASKFILE     = 3'd0,
      KIND_READ_SECTOR  = 3'd1,
      KIND_WRITE_SECTOR = 3'd2,
      KIND_DONE         = 3'd3,
      KIND_ERROR        = 3'd4,
      KIND_FULL         = 3'd5
   } kind_type;

   // Input transaction
   typedef struct packed {
      logic               command;
      logic [LBA_W-1:0]   lba;
      logic [COUNT_W-1:0] sector_total;
      logic               is_write;
      logic               to_slave;
      logic               stat_busy;
      logic               stat_drq;
      logic               stat_ready;
      logic               stat_error;
   } req_type;

   // Result transaction
   typedef struct packed {
      kind_type           kind;
      logic [1:0]         op;
      logic [LBA_W-1:0]   issue_lba;
      logic [COUNT_W-1:0] issue_count;
      logic               issue_slave;
      logic [COUNT_W-1:0] sector_index;
      logic               last;
   } rsp_type;

   // Queue entry: one pending request
   typedef struct packed {
      logic               is_write;
      logic [COUNT_W-1:0] count;
      logic [LBA_W-1:0]   lba;
   } entry_type;

   // Engine to queue control
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   // Queue to engine status
   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   // Operation code: DMA flag over write flag
   function automatic logic [1:0] op_code(input logic dma, input logic wr);
      op_code = {dma, wr};
   endfunction

   // Build a result with last cleared
   function automatic rsp_type make_rsp(input kind_type           kind,
                                        input logic [1:0]         op,
                                        input logic [LBA_W-1:0]   lba,
                                        input logic [COUNT_W-1:0] count,
                                        input logic               slave,
                                        input logic [COUNT_W-1:0] idx);
      rsp_type r;
      r.kind         = kind;
      r.op           = op;
      r.issue_lba    = lba;
      r.issue_count  = count;
      r.issue_slave  = slave;
      r.sector_index = idx;
      r.last         = 1'b0;
      make_rsp = r;
   endfunction

endpackage

### rtl/core/ata_rs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_rs_fifo - request queue for one drive
// Register-file FIFO with a fill count; the head reads through to the push
// data when the queue is empty so a request can be queued and started at once.
// ----------------------------------------------------------------------------
`include "ata_request_sequencer_assert.svh"

module ata_rs_fifo
   import ata_rs_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  fifo_ctrl_type   ctrl,
   input  entry_type       push_data,
   output entry_type       head_data,
   output fifo_status_type status
);

   entry_type         mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // Status and head read with empty bypass
   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign head_data    = status.empty ? push_data : mem[head_ff];

   // Pointer and fill update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.push) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (ctrl.pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (!ctrl.push && ctrl.pop) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= push_data;
      end
   end

   // Checks
   `ATA_RS_ASSERT_NOW(a_push_not_full, ctrl.push, !status.full)
   `ATA_RS_ASSERT_NOW(a_pop_has_data, ctrl.pop, (!status.empty || ctrl.push))
   `ATA_RS_ASSERT_NEXT(a_fill_grows, (ctrl.push && !ctrl.pop), (fill_ff == $past(fill_ff) + FILL_W'(1)))

endmodule

### rtl/core/ata_rs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_rs_engine - request state and per-transaction decision logic
// Holds both queues, the active request and the mode register; for one input
// transaction it works out up to three results and the next state.
// ----------------------------------------------------------------------------
module ata_rs_engine
   import ata_rs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  logic                 fire,
   input  req_type              item,
   output rsp_type              res_list [MAX_RESULTS],
   output logic [RES_CNT_W-1:0] res_count
);

   // Mode register
   logic use_dma_ff;

   // Active request
   logic               active_ff, active_in;
   logic               active_write_ff, active_write_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] next_ff, next_in;
   logic [LBA_W-1:0]   cur_lba_ff, cur_lba_in;
   logic [COUNT_W-1:0] cur_count_ff, cur_count_in;
   logic               cur_slave_ff, cur_slave_in;
   logic               cur_dma_ff, cur_dma_in;

   // Queue interface
   fifo_ctrl_type   m_ctrl, s_ctrl, m_ctrl_q, s_ctrl_q;
   fifo_status_type m_stat, s_stat;
   entry_type       m_head, s_head, new_entry;

   // Decision temporaries
   rsp_type            res [MAX_RESULTS];
   logic [RES_CNT_W-1:0] n;
   logic [COUNT_W-1:0] cnt_fix;
   logic [COUNT_W-1:0] rem_dec;
   logic [1:0]         cur_op;
   logic               start;
   logic               start_go;
   logic               start_slave;
   entry_type          start_ent;

   // Queues
   ata_rs_fifo u_master_q (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (m_ctrl_q),
      .push_data (new_entry),
      .head_data (m_head),
      .status    (m_stat)
   );

   ata_rs_fifo u_slave_q (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (s_ctrl_q),
      .push_data (new_entry),
      .head_data (s_head),
      .status    (s_stat)
   );

   // Queue strobes only move on a processed transaction
   always_comb begin
      m_ctrl_q.push = m_ctrl.push && fire;
      m_ctrl_q.pop  = m_ctrl.pop && fire;
      s_ctrl_q.push = s_ctrl.push && fire;
      s_ctrl_q.pop  = s_ctrl.pop && fire;
   end

   // Zero count is taken as one sector
   assign cnt_fix   = (item.sector_total == '0) ? COUNT_W'(1) : item.sector_total;
   assign new_entry = '{is_write: item.is_write, count: cnt_fix, lba: item.lba};
   assign cur_op    = op_code(cur_dma_ff, active_write_ff);
   assign rem_dec   = (rem_ff != '0) ? rem_ff - COUNT_W'(1) : '0;

   // Decision logic
   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i] = '0;
      end
      n               = '0;
      m_ctrl          = '0;
      s_ctrl          = '0;
      start           = 1'b0;
      start_go        = 1'b0;
      start_slave     = 1'b0;
      start_ent       = m_head;
      active_in       = active_ff;
      active_write_in = active_write_ff;
      rem_in          = rem_ff;
      next_in         = next_ff;
      cur_lba_in      = cur_lba_ff;
      cur_count_in    = cur_count_ff;
      cur_slave_in    = cur_slave_ff;
      cur_dma_in      = cur_dma_ff;

      if (item.command == CMD_ENQUEUE) begin
         // Queue the request, or report a full queue and drop it
         if ((item.to_slave && s_stat.full) || (!item.to_slave && m_stat.full)) begin
            res[n] = make_rsp(KIND_FULL, op_code(use_dma_ff, item.is_write), item.lba,
                              cnt_fix, item.to_slave, '0);
            n      = n + RES_CNT_W'(1);
         end else if (item.to_slave) begin
            s_ctrl.push = 1'b1;
         end else begin
            m_ctrl.push = 1'b1;
         end
         start = !active_ff;
      end else if (active_ff && !item.stat_busy) begin
         if (item.stat_error || (!item.stat_drq && !item.stat_ready)) begin
            // Error status aborts the request
            res[n]    = make_rsp(KIND_ERROR, cur_op, cur_lba_ff, cur_count_ff,
                                 cur_slave_ff, next_ff);
            n         = n + RES_CNT_W'(1);
            active_in = 1'b0;
            start     = 1'b1;
         end else if (cur_dma_ff) begin
            // DMA completes on one interrupt
            res[n]    = make_rsp(KIND_DONE, cur_op, cur_lba_ff, cur_count_ff,
                                 cur_slave_ff, '0);
            n         = n + RES_CNT_W'(1);
            active_in = 1'b0;
            start     = 1'b1;
         end else if (!active_write_ff) begin
            // PIO read: one sector per interrupt, the final one reports done
            rem_in  = rem_dec;
            next_in = next_ff + COUNT_W'(1);
            if (rem_dec == '0) begin
               res[n]    = make_rsp(KIND_DONE, cur_op, cur_lba_ff, cur_count_ff,
                                    cur_slave_ff, next_ff);
               active_in = 1'b0;
               start     = 1'b1;
            end else begin
               res[n] = make_rsp(KIND_READ_SECTOR, cur_op, cur_lba_ff, cur_count_ff,
                                 cur_slave_ff, next_ff);
            end
            n = n + RES_CNT_W'(1);
         end else if (rem_ff == '0) begin
            // PIO write finished
            res[n]    = make_rsp(KIND_DONE, cur_op, cur_lba_ff, cur_count_ff,
                                 cur_slave_ff, '0);
            n         = n + RES_CNT_W'(1);
            active_in = 1'b0;
            start     = 1'b1;
         end else begin
            // PIO write: send the next sector
            res[n]  = make_rsp(KIND_WRITE_SECTOR, cur_op, cur_lba_ff, cur_count_ff,
                               cur_slave_ff, next_ff);
            n       = n + RES_CNT_W'(1);
            rem_in  = rem_ff - COUNT_W'(1);
            next_in = next_ff + COUNT_W'(1);
         end
      end

      // Start the next request, master first
      if (start) begin
         if (!m_stat.empty || m_ctrl.push) begin
            m_ctrl.pop  = 1'b1;
            start_ent   = m_head;
            start_slave = 1'b0;
            start_go    = 1'b1;
         end else if (!s_stat.empty || s_ctrl.push) begin
            s_ctrl.pop  = 1'b1;
            start_ent   = s_head;
            start_slave = 1'b1;
            start_go    = 1'b1;
         end
      end

      if (start_go) begin
         active_in       = 1'b1;
         active_write_in = start_ent.is_write;
         cur_lba_in      = start_ent.lba;
         cur_count_in    = start_ent.count;
         cur_slave_in    = start_slave;
         cur_dma_in      = use_dma_ff;
         rem_in          = start_ent.count;
         next_in         = '0;
         res[n] = make_rsp(KIND_TASKFILE, op_code(use_dma_ff, start_ent.is_write),
                           start_ent.lba, start_ent.count, start_slave, '0);
         n      = n + RES_CNT_W'(1);
         // PIO write sends its first sector with the command
         if (!use_dma_ff && start_ent.is_write) begin
            res[n]  = make_rsp(KIND_WRITE_SECTOR, op_code(use_dma_ff, start_ent.is_write),
                               start_ent.lba, start_ent.count, start_slave, '0);
            n       = n + RES_CNT_W'(1);
            rem_in  = start_ent.count - COUNT_W'(1);
            next_in = COUNT_W'(1);
         end
      end

      // Mark the final result
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i].last = (RES_CNT_W'(i) == n - RES_CNT_W'(1));
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_list[i] = res[i];
      end
   end
   assign res_count = n;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         use_dma_ff <= 1'b0;
      end else if (csr_wr_en) begin
         use_dma_ff <= csr_wr_data;
      end
   end

   // Active request control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         active_write_ff <= 1'b0;
         rem_ff          <= '0;
         next_ff         <= '0;
      end else if (fire) begin
         active_ff       <= active_in;
         active_write_ff <= active_write_in;
         rem_ff          <= rem_in;
         next_ff         <= next_in;
      end
   end

   // Active request payload
   always_ff @(posedge clock) begin
      if (fire) begin
         cur_lba_ff   <= cur_lba_in;
         cur_count_ff <= cur_count_in;
         cur_slave_ff <= cur_slave_in;
         cur_dma_ff   <= cur_dma_in;
      end
   end

endmodule

### rtl/core/ata_request_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_request_sequencer - host-side ATA LBA28 request sequencer
// Queues read and write requests per drive and sequences task-file, sector,
// completion and error events from drive interrupts.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input transactions (enqueue a request, or an interrupt with the
//            drive status). Taken when req_valid is high and req_stall low.
//   rsp_*  : result transactions, zero to three per input, the final one
//            flagged by last. Taken when rsp_valid is high and rsp_stall low.
//   csr_*  : use_dma mode bit, written when csr_wr_en is high; the mode is
//            latched per request when its task file is issued.
//   Flow: an input lands in the input register, is decided once the result
//   buffer is empty, and its results are offered from the result buffer register.
//   Throughput: one input per cycle while inputs cause no result; otherwise
//   the three-entry result buffer must drain before the next decision.
//   A new input is taken into the input register while results still drain.
//   Reset clears the queues, the active request, the mode bit and all
//   handshake state. When the receiver stalls, the current result holds and
//   req_stall rises once the input register is also occupied.
// ----------------------------------------------------------------------------
`include "ata_request_sequencer_assert.svh"

module ata_request_sequencer
   import ata_rs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   // Input register
   req_type in_ff;
   logic    in_valid_ff, in_valid_in;

   // Result buffer
   rsp_type              buf_ff [MAX_RESULTS];
   logic [RES_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RES_CNT_W-1:0] rd_ff, rd_in;

   rsp_type              res_list [MAX_RESULTS];
   logic [RES_CNT_W-1:0] res_count;
   logic                 fire;
   logic                 req_take;
   logic                 rsp_take;

   // Handshake
   assign fire      = in_valid_ff && (cnt_ff == '0);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_data  = buf_ff[rd_ff];

   ata_rs_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (fire),
      .item        (in_ff),
      .res_list    (res_list),
      .res_count   (res_count)
   );

   // Input register control
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
   end

   // Result buffer control: load on a decision, drain one per take
   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      if (fire) begin
         cnt_in = res_count;
         rd_in  = '0;
      end else if (rsp_take) begin
         cnt_in = cnt_ff - RES_CNT_W'(1);
         rd_in  = rd_ff + RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_ff[i] <= res_list[i];
         end
      end
   end

   // Checks
   `ATA_RS_ASSERT_NOW(a_buf_in_range, rsp_valid, ((3'(rd_ff) + 3'(cnt_ff)) <= 3'(MAX_RESULTS)))
   `ATA_RS_ASSERT_NOW(a_last_on_final, (cnt_ff == RES_CNT_W'(1)), rsp_data.last)
   `ATA_RS_ASSERT_NOW(a_no_early_last, (cnt_ff > RES_CNT_W'(1)), !rsp_data.last)

endmodule
